// ===== hdl/uart_receive_buffer_events_top_assert.svh =====
// Assertion macros used by the receive buffer controller.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef UART_RECEIVE_BUFFER_EVENTS_TOP_ASSERT_SVH
`define UART_RECEIVE_BUFFER_EVENTS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define URBE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define URBE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in next cycle");

`endif

// ===== hdl/urbe_pkg.sv =====
// Shared types and constants for the UART receive buffer block.
// No dependencies; imported by the controller, the datapath and the top level.
package urbe_pkg;

	localparam int BUF_DEPTH = 256;
	localparam int IDX_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = 9;
	localparam int CFG_W = 9;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		CMD_STATUS = 2'd0,
		CMD_READ = 2'd1,
		CMD_TAKE = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_RECEIVED = 3'd1,
		EV_OVERFLOW = 3'd2,
		EV_ENDCHAR = 3'd3,
		EV_TXDONE = 3'd4,
		EV_IDLE = 3'd5
	} ev_t;

	localparam logic [1:0] MODE_IDLE = 2'd1;
	localparam logic [1:0] MODE_ENDCHAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RX_CAPACITY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECEPTION_MODE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_CHARACTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_IRQ_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TX_IRQ_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_IRQ_ENABLE = 3'd5;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic exec;     // perform the accepted transaction
		logic load_rd;  // load the result of a buffer read
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
	} dp_sts_t;

endpackage

// ===== hdl/urbe_ctrl.sv =====
// Controller state machine for the UART receive buffer: handshakes and sequencing.
// Depends on urbe_pkg and the assertion macro header.
`include "uart_receive_buffer_events_top_assert.svh"

module urbe_ctrl
	import urbe_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				// The output register is free or is being emptied this cycle.
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.exec = 1'b1;
					if (sts.is_read) begin
						state_d = ST_READ;
					end else begin
						out_valid_d = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.load_rd = 1'b1;
				out_valid_d = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`URBE_ASSERT_NEXT(a_read_waits_for_data, in_valid && in_ready && sts.is_read, state_q == ST_READ && !out_valid)
	`URBE_ASSERT_NEXT(a_read_delivers, state_q == ST_READ, out_valid && state_q == ST_IDLE)
	`URBE_ASSERT_IMP(a_no_result_overwrite, in_valid && in_ready && out_valid, out_ready)

endmodule

// ===== hdl/urbe_datapath.sv =====
// Datapath for the UART receive buffer: configuration, byte store, count and results.
// Depends on urbe_pkg; sequenced by urbe_ctrl.
module urbe_datapath
	import urbe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [1:0]           command,
	input  logic                 rx_ready,
	input  logic                 tx_done,
	input  logic                 line_idle,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           read_index,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic [2:0]           event_res,
	output logic [CNT_W-1:0]     stored_count,
	output logic [7:0]           read_byte
);

	logic [CNT_W-1:0] rx_capacity_q;
	logic [1:0]       reception_mode_q;
	logic [7:0]       end_character_q;
	logic             rx_irq_enable_q;
	logic             tx_irq_enable_q;
	logic             idle_irq_enable_q;

	logic [CNT_W-1:0] count_q, count_d;
	logic [7:0]       store [BUF_DEPTH];
	logic [7:0]       rd_data_s1;
	logic             rd_oob_s1;

	ev_t              out_event_q;
	logic [CNT_W-1:0] out_count_q;
	logic [7:0]       out_byte_q;

	logic [CNT_W-1:0] cap_eff;
	logic             full;
	logic             store_wr;
	ev_t              ev_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_capacity_q <= '0;
			reception_mode_q <= '0;
			end_character_q <= '0;
			rx_irq_enable_q <= 1'b0;
			tx_irq_enable_q <= 1'b0;
			idle_irq_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RX_CAPACITY: rx_capacity_q <= cfg_data;
				CFG_RECEPTION_MODE: reception_mode_q <= cfg_data[1:0];
				CFG_END_CHARACTER: end_character_q <= cfg_data[7:0];
				CFG_RX_IRQ_ENABLE: rx_irq_enable_q <= cfg_data[0];
				CFG_TX_IRQ_ENABLE: tx_irq_enable_q <= cfg_data[0];
				CFG_IDLE_IRQ_ENABLE: idle_irq_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sts.is_read = (command == CMD_READ);

	// The capacity in effect never exceeds the store depth.
	assign cap_eff = (rx_capacity_q > CNT_W'(BUF_DEPTH)) ? CNT_W'(BUF_DEPTH) : rx_capacity_q;
	assign full = (count_q >= cap_eff) || (count_q >= CNT_W'(BUF_DEPTH));

	always_comb begin
		count_d = count_q;
		ev_d = EV_NONE;
		store_wr = 1'b0;
		unique case (command)
			CMD_STATUS: begin
				if (rx_ready && rx_irq_enable_q) begin
					if (full) begin
						ev_d = EV_OVERFLOW;
					end else begin
						store_wr = 1'b1;
						count_d = count_q + CNT_W'(1);
						if (reception_mode_q == MODE_ENDCHAR && rx_byte == end_character_q) begin
							ev_d = EV_ENDCHAR;
						end else begin
							ev_d = EV_RECEIVED;
						end
					end
				end else if (tx_done && tx_irq_enable_q) begin
					ev_d = EV_TXDONE;
				end else if (line_idle && idle_irq_enable_q && reception_mode_q == MODE_IDLE) begin
					ev_d = EV_IDLE;
				end
			end
			CMD_TAKE: begin
				count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// Single-port style store: at most one write and one registered read per transaction.
	always_ff @(posedge clk) begin
		if (cmd.exec && store_wr) begin
			store[count_q[IDX_W-1:0]] <= rx_byte;
		end
		if (cmd.exec) begin
			rd_data_s1 <= store[read_index[IDX_W-1:0]];
			rd_oob_s1 <= (32'(read_index) >= BUF_DEPTH);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_event_q <= ev_d;
			out_count_q <= count_d;
			out_byte_q <= '0;
		end else if (cmd.load_rd) begin
			out_event_q <= EV_NONE;
			out_count_q <= count_q;
			out_byte_q <= rd_oob_s1 ? 8'd0 : rd_data_s1;
		end
	end

	assign event_res = out_event_q;
	assign stored_count = out_count_q;
	assign read_byte = out_byte_q;

endmodule

// ===== hdl/uart_receive_buffer_events_top.sv =====
// UART receive buffer with interrupt events: top level joining controller and datapath.
// Depends on urbe_pkg, urbe_ctrl and urbe_datapath.
//
// Usage:
// Input items arrive on a valid/ready channel (command, rx_ready, tx_done, line_idle,
// rx_byte, read_index); each accepted transaction produces exactly one result
// (event_res, stored_count, read_byte) on a valid/ready output channel.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no transaction is in flight, which the block does not enforce.
// Status and take commands show their result in the cycle after acceptance; a read
// command first passes through ST_READ, as the byte store has a registered read port.
// Throughput: one transaction per cycle for status and take commands while out_ready is
// high; a read blocks new transactions while it waits in ST_READ for its stored byte.
// A new transaction is accepted in the same cycle the pending result is taken.
// Reset clears the configuration, the byte count and the controller; the byte store
// is not cleared, and its entries hold garbage until written.
// When the receiver holds out_ready low, the result stays registered and in_ready
// stays low until it is taken.
module uart_receive_buffer_events_top
	import urbe_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           command,
	input  logic                 rx_ready,
	input  logic                 tx_done,
	input  logic                 line_idle,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           read_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           event_res,
	output logic [CNT_W-1:0]     stored_count,
	output logic [7:0]           read_byte
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	urbe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	urbe_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.rx_ready     (rx_ready),
		.tx_done      (tx_done),
		.line_idle    (line_idle),
		.rx_byte      (rx_byte),
		.read_index   (read_index),
		.cmd          (dp_cmd),
		.sts          (dp_sts),
		.event_res    (event_res),
		.stored_count (stored_count),
		.read_byte    (read_byte)
	);

endmodule
